[src/pps_pkg.sv]
// Shared types and constants for the polygon plane split core.
package pps_pkg;

    // Vertex side codes
    typedef enum logic [1:0] {
        SIDE_ON    = 2'd0,
        SIDE_FRONT = 2'd1,
        SIDE_BACK  = 2'd2
    } side_t;

    // Register indexes
    localparam logic [2:0] REG_NORMAL_X = 3'd0;
    localparam logic [2:0] REG_NORMAL_Y = 3'd1;
    localparam logic [2:0] REG_NORMAL_Z = 3'd2;
    localparam logic [2:0] REG_OFFSET   = 3'd3;
    localparam logic [2:0] REG_EPSILON  = 3'd4;

    localparam int MIN_HALF = 3;
    localparam int DIV_STEPS = 31;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DOT,
        ST_CLASS,
        ST_DIV_SETUP,
        ST_DIV,
        ST_MUL,
        ST_EMIT_ISECT,
        ST_EMIT_VERT,
        ST_EMIT_CLOSE,
        ST_DONE
    } state_t;

endpackage

[src/polygon_plane_split_core.sv]
// Top level: iterative polygon splitter against a configured plane.
//
// Usage: vertex words enter on the s_ channel (vert_x/y/z, last_vertex),
// one polygon after another; the final vertex of a polygon carries
// last_vertex. Result words leave on the m_ channel in polygon order
// v0, I01, v1, ..., v(n-1), I(n-1,0); each says whether it belongs to the
// front half, the back half or both. The last result of a polygon carries
// last_result, split_ok and overflow.
// The plane should be written through the APB port only while the block is
// idle; the block itself does not enforce this. One shared 33x33 multiplier
// forms the three dot-product terms and the three intersection offsets, one
// product per cycle; a 31-step restoring divider forms the edge parameter,
// one quotient bit per cycle. Each crossing edge adds a divider setup, 31
// divider steps, three multiplies and an emit; an edge whose parameter is not
// below one skips the steps and multiplies and emits an endpoint. Worst case
// is a closing vertex with two crossings. s_ready is low while a vertex is
// being worked on. Each result waits in the output register until m_ready
// takes it; the sequencer stalls there.
// Synchronous active-low reset clears the sequencer, the polygon counts
// and loads the register defaults.
module polygon_plane_split_core #(
    parameter int MAX_VERTS = 32
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [31:0] s_vert_x,
    input  logic signed [31:0] s_vert_y,
    input  logic signed [31:0] s_vert_z,
    input  logic               s_last_vertex,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_out_x,
    output logic signed [31:0] m_out_y,
    output logic signed [31:0] m_out_z,
    output logic               m_to_front,
    output logic               m_to_back,
    output logic               m_is_intersection,
    output logic               m_last_result,
    output logic               m_split_ok,
    output logic               m_overflow
);

    localparam int CW = $clog2(MAX_VERTS + 2);

    // Configuration registers
    logic signed [31:0] nx_reg, ny_reg, nz_reg, off_reg;
    logic [30:0]        eps_reg;
    logic [2:0]         widx;
    assign widx   = paddr[4:2];
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nx_reg  <= '0;
            ny_reg  <= '0;
            nz_reg  <= 32'sd65536;
            off_reg <= '0;
            eps_reg <= 31'd6554;
        end else if (psel && penable && pwrite) begin
            case (widx)
                pps_pkg::REG_NORMAL_X: nx_reg  <= pwdata;
                pps_pkg::REG_NORMAL_Y: ny_reg  <= pwdata;
                pps_pkg::REG_NORMAL_Z: nz_reg  <= pwdata;
                pps_pkg::REG_OFFSET:   off_reg <= pwdata;
                pps_pkg::REG_EPSILON:  eps_reg <= pwdata[30:0];
                default: ;
            endcase
        end
    end

    // Register readback
    always_comb begin
        case (widx)
            pps_pkg::REG_NORMAL_X: prdata = nx_reg;
            pps_pkg::REG_NORMAL_Y: prdata = ny_reg;
            pps_pkg::REG_NORMAL_Z: prdata = nz_reg;
            pps_pkg::REG_OFFSET:   prdata = off_reg;
            pps_pkg::REG_EPSILON:  prdata = {1'b0, eps_reg};
            default:               prdata = '0;
        endcase
    end

    // Sequencer and datapath registers
    pps_pkg::state_t    state_reg, state_next;
    logic signed [31:0] v_reg [3];
    logic               last_reg;
    logic signed [63:0] d_reg;
    pps_pkg::side_t     s_reg;
    logic signed [31:0] fv_reg [3];
    logic signed [63:0] fd_reg;
    pps_pkg::side_t     fs_reg;
    logic signed [31:0] pv_reg [3];
    logic signed [63:0] pd_reg;
    pps_pkg::side_t     ps_reg;
    logic [5:0]         vcnt_reg;
    logic [CW-1:0]      fcnt_reg, bcnt_reg;
    logic [1:0]         step_reg;
    logic [4:0]         dcnt_reg;
    logic [63:0]        rem_reg, den_reg;
    logic [30:0]        t_reg;
    logic               close_reg;   // working on the closing edge
    logic               usea_reg;    // result is vertex a
    logic               useb_reg;    // result is vertex b
    logic signed [31:0] x_reg [3];   // intersection result

    // Edge endpoints: a then b
    logic signed [31:0] ea [3];
    logic signed [31:0] eb [3];
    logic signed [63:0] eda, edb;
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            ea[i] = close_reg ? v_reg[i]  : pv_reg[i];
            eb[i] = close_reg ? fv_reg[i] : v_reg[i];
        end
        eda = close_reg ? d_reg  : pd_reg;
        edb = close_reg ? fd_reg : d_reg;
    end

    // Shared multiplier: signed 33x33 inputs, one product per cycle
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] mul_p;
    logic signed [32:0] diff;
    always_comb begin
        diff = 33'(eb[step_reg]) - 33'(ea[step_reg]);
        if (state_reg == pps_pkg::ST_DOT) begin
            mul_a = 33'(v_reg[step_reg]);
            case (step_reg)
                2'd0:    mul_b = 33'(nx_reg);
                2'd1:    mul_b = 33'(ny_reg);
                default: mul_b = 33'(nz_reg);
            endcase
        end else begin
            mul_a = diff[32] ? -diff : diff;
            mul_b = {2'b00, t_reg};
        end
        mul_p = mul_a * mul_b;
    end

    // Side of the finished dot product against the epsilon band
    pps_pkg::side_t cls_side;
    always_comb begin
        if (d_reg > $signed({33'd0, eps_reg}))
            cls_side = pps_pkg::SIDE_FRONT;
        else if (d_reg < -$signed({33'd0, eps_reg}))
            cls_side = pps_pkg::SIDE_BACK;
        else
            cls_side = pps_pkg::SIDE_ON;
    end

    // Opposite-side test
    function automatic logic opp(pps_pkg::side_t a, pps_pkg::side_t b);
        return (a == pps_pkg::SIDE_FRONT && b == pps_pkg::SIDE_BACK) ||
               (a == pps_pkg::SIDE_BACK && b == pps_pkg::SIDE_FRONT);
    endfunction

    logic cross_open, cross_close;
    assign cross_open  = (vcnt_reg != 6'd0) && opp(ps_reg, cls_side);
    assign cross_close = (vcnt_reg != 6'd0) && opp(s_reg, fs_reg);

    // Divider step
    logic [63:0] rem_sh;
    logic        q_bit;
    assign rem_sh = {rem_reg[62:0], 1'b0};
    assign q_bit  = rem_sh >= den_reg;

    // Divider setup values
    logic signed [63:0] den_s;
    logic [63:0]        num_m, den_m;
    assign den_s = eda - edb;
    assign num_m = eda[63] ? 64'(-eda) : 64'(eda);
    assign den_m = den_s[63] ? 64'(-den_s) : 64'(den_s);

    logic out_busy, out_take;
    assign out_take = m_valid && m_ready;
    assign out_busy = m_valid && !m_ready;

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            pps_pkg::ST_IDLE:
                if (s_valid) state_next = pps_pkg::ST_DOT;
            pps_pkg::ST_DOT:
                if (step_reg == 2'd2) state_next = pps_pkg::ST_CLASS;
            pps_pkg::ST_CLASS:
                state_next = cross_open ? pps_pkg::ST_DIV_SETUP : pps_pkg::ST_EMIT_VERT;
            pps_pkg::ST_DIV_SETUP:
                state_next = (den_s == 0 || num_m >= den_m) ? pps_pkg::ST_EMIT_ISECT
                                                             : pps_pkg::ST_DIV;
            pps_pkg::ST_DIV:
                if (dcnt_reg == 5'(pps_pkg::DIV_STEPS - 1)) state_next = pps_pkg::ST_MUL;
            pps_pkg::ST_MUL:
                if (step_reg == 2'd2) state_next = pps_pkg::ST_EMIT_ISECT;
            pps_pkg::ST_EMIT_ISECT:
                if (!out_busy)
                    state_next = close_reg ? pps_pkg::ST_DONE : pps_pkg::ST_EMIT_VERT;
            pps_pkg::ST_EMIT_VERT:
                if (!out_busy)
                    state_next = (last_reg && cross_close) ? pps_pkg::ST_DIV_SETUP
                                                           : pps_pkg::ST_DONE;
            pps_pkg::ST_DONE:
                if (!out_busy) state_next = pps_pkg::ST_IDLE;
            default: state_next = pps_pkg::ST_IDLE;
        endcase
    end

    assign s_ready = (state_reg == pps_pkg::ST_IDLE);

    // Count increments for emitted words
    function automatic logic [CW-1:0] bump(logic [CW-1:0] c, logic en);
        return (en && c <= CW'(MAX_VERTS)) ? c + 1'b1 : c;
    endfunction

    logic emit_v, emit_i, vf, vb, fin;
    logic [CW-1:0] fc_new, bc_new;
    always_comb begin
        emit_i = (state_reg == pps_pkg::ST_EMIT_ISECT) && !out_busy;
        emit_v = (state_reg == pps_pkg::ST_EMIT_VERT) && !out_busy;
        vf = s_reg != pps_pkg::SIDE_BACK;
        vb = s_reg != pps_pkg::SIDE_FRONT;
        fc_new = bump(fcnt_reg, emit_i || (emit_v && vf));
        bc_new = bump(bcnt_reg, emit_i || (emit_v && vb));
        // this word ends the polygon
        fin = last_reg && ((emit_v && !cross_close) || (emit_i && close_reg));
    end

    // Datapath
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= pps_pkg::ST_IDLE;
            vcnt_reg  <= '0;
            fcnt_reg  <= '0;
            bcnt_reg  <= '0;
            m_valid   <= 1'b0;
            fs_reg    <= pps_pkg::SIDE_ON;
            ps_reg    <= pps_pkg::SIDE_ON;
            fd_reg    <= '0;
            pd_reg    <= '0;
            for (int i = 0; i < 3; i++) begin
                fv_reg[i] <= '0;
                pv_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            // word taken and no new one loaded behind it
            if (out_take && !(emit_i || emit_v)) m_valid <= 1'b0;
            case (state_reg)
                pps_pkg::ST_IDLE: begin
                    if (s_valid) begin
                        v_reg[0]  <= s_vert_x;
                        v_reg[1]  <= s_vert_y;
                        v_reg[2]  <= s_vert_z;
                        last_reg  <= s_last_vertex;
                        d_reg     <= -64'(off_reg);
                        step_reg  <= '0;
                        close_reg <= 1'b0;
                    end
                end
                pps_pkg::ST_DOT: begin
                    // floor to Q16.16 and accumulate
                    d_reg    <= d_reg + 64'(mul_p >>> 16);
                    step_reg <= step_reg + 1'b1;
                end
                pps_pkg::ST_CLASS: begin
                    s_reg <= cls_side;
                end
                pps_pkg::ST_DIV_SETUP: begin
                    usea_reg <= den_s == 0;
                    useb_reg <= den_s != 0 && num_m >= den_m;
                    rem_reg  <= num_m;
                    den_reg  <= den_m;
                    t_reg    <= '0;
                    dcnt_reg <= '0;
                    step_reg <= '0;
                end
                pps_pkg::ST_DIV: begin
                    rem_reg  <= q_bit ? rem_sh - den_reg : rem_sh;
                    t_reg    <= {t_reg[29:0], q_bit};
                    dcnt_reg <= dcnt_reg + 1'b1;
                end
                pps_pkg::ST_MUL: begin
                    // round half away, move from a toward b
                    logic [63:0] offv;
                    offv = 64'((mul_p + 66'sd1073741824) >>> 31);
                    x_reg[step_reg] <= diff[32] ? ea[step_reg] - 32'(offv)
                                                : ea[step_reg] + 32'(offv);
                    step_reg <= step_reg + 1'b1;
                end
                pps_pkg::ST_EMIT_ISECT: begin
                    if (!out_busy) begin
                        m_valid <= 1'b1;
                        for (int i = 0; i < 3; i++) begin
                            if (usea_reg)      x_reg[i] <= ea[i];
                            else if (useb_reg) x_reg[i] <= eb[i];
                        end
                        m_out_x <= usea_reg ? ea[0] : (useb_reg ? eb[0] : x_reg[0]);
                        m_out_y <= usea_reg ? ea[1] : (useb_reg ? eb[1] : x_reg[1]);
                        m_out_z <= usea_reg ? ea[2] : (useb_reg ? eb[2] : x_reg[2]);
                        m_to_front <= 1'b1;
                        m_to_back  <= 1'b1;
                        m_is_intersection <= 1'b1;
                        fcnt_reg <= fc_new;
                        bcnt_reg <= bc_new;
                    end
                end
                pps_pkg::ST_EMIT_VERT: begin
                    if (!out_busy) begin
                        m_valid <= 1'b1;
                        m_out_x <= v_reg[0];
                        m_out_y <= v_reg[1];
                        m_out_z <= v_reg[2];
                        m_to_front <= vf;
                        m_to_back  <= vb;
                        m_is_intersection <= 1'b0;
                        fcnt_reg <= fc_new;
                        bcnt_reg <= bc_new;
                        if (vcnt_reg == 6'd0) begin
                            fv_reg <= v_reg;
                            fd_reg <= d_reg;
                            fs_reg <= s_reg;
                        end
                        close_reg <= 1'b1;
                    end
                end
                pps_pkg::ST_DONE: begin
                    if (!out_busy) begin
                        if (last_reg) begin
                            vcnt_reg <= '0;
                            fcnt_reg <= '0;
                            bcnt_reg <= '0;
                            fs_reg   <= pps_pkg::SIDE_ON;
                            ps_reg   <= pps_pkg::SIDE_ON;
                            fd_reg   <= '0;
                            pd_reg   <= '0;
                            for (int i = 0; i < 3; i++) begin
                                fv_reg[i] <= '0;
                                pv_reg[i] <= '0;
                            end
                        end else begin
                            pv_reg <= v_reg;
                            pd_reg <= d_reg;
                            ps_reg <= s_reg;
                            if (vcnt_reg != 6'd63) vcnt_reg <= vcnt_reg + 1'b1;
                        end
                    end
                end
                default: ;
            endcase
            // polygon status on the final word
            if (emit_i || emit_v) begin
                m_last_result <= fin;
                m_split_ok <= fin && fc_new >= CW'(pps_pkg::MIN_HALF)
                                  && bc_new >= CW'(pps_pkg::MIN_HALF);
                m_overflow <= fin && (fc_new > CW'(MAX_VERTS) || bc_new > CW'(MAX_VERTS));
            end
        end
    end

endmodule

[src/pps_checker.sv]
// Port-level checker for the polygon plane split core, with its bind.
module pps_checker (
    input logic aclk,
    input logic aresetn,
    input logic s_valid,
    input logic s_ready,
    input logic m_valid,
    input logic m_ready,
    input logic m_last_result,
    input logic m_split_ok,
    input logic m_overflow,
    input logic m_to_front,
    input logic m_to_back,
    input logic m_is_intersection
);

    // A result word holds until taken
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result word dropped while stalled");

    // No new vertex while a result is pending
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready)
        else $error("input ready with pending result");

    // An accepted vertex keeps the input closed on the next cycle
    a_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input ready right after a vertex word");

    // Status flags only on the last word
    a_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_last_result |-> !m_split_ok && !m_overflow)
        else $error("status flag off the last word");

    // Intersections go to both halves
    a_isect: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_is_intersection |-> m_to_front && m_to_back)
        else $error("intersection not in both halves");

endmodule

bind polygon_plane_split_core pps_checker u_pps_checker (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_last_result(m_last_result),
    .m_split_ok(m_split_ok), .m_overflow(m_overflow), .m_to_front(m_to_front),
    .m_to_back(m_to_back), .m_is_intersection(m_is_intersection)
);
